### rtl/itpt_pkg.sv
// Shared constants, types and helpers for the integer-to-text renderer.
// No dependencies; imported by every module of the block.
package itpt_pkg;

  localparam int unsigned VALUE_WIDTH  = 64;
  localparam int unsigned MAX_CHARS    = 64;
  localparam int unsigned VALUE_PORT_W = 64;
  localparam int unsigned RADIX_W      = 6;
  localparam int unsigned FIELD_W      = 7;
  localparam int unsigned FLAGS_W      = 7;
  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned POS_W        = 6;
  localparam int unsigned DIGIT_W      = 6;

  localparam int unsigned RADIX_MIN = 2;
  localparam int unsigned RADIX_MAX = 36;
  localparam int unsigned RADIX_OCT = 8;
  localparam int unsigned RADIX_HEX = 16;

  // Divider retires DIV_BITS quotient bits per cycle.
  localparam int unsigned DIV_BITS  = 8;
  localparam int unsigned DIV_STEPS = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
  localparam int unsigned DIV_W     = DIV_STEPS * DIV_BITS;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS + 1);

  localparam int unsigned STACK_DEPTH = VALUE_WIDTH;
  localparam int unsigned NDIG_W      = $clog2(STACK_DEPTH + 1);

  // Format flag bit positions
  localparam int unsigned FLAG_LEFT   = 0;
  localparam int unsigned FLAG_ZERO   = 1;
  localparam int unsigned FLAG_SIGNED = 2;
  localparam int unsigned FLAG_PLUS   = 3;
  localparam int unsigned FLAG_SPACE  = 4;
  localparam int unsigned FLAG_ALT    = 5;
  localparam int unsigned FLAG_UPPER  = 6;

  localparam logic [CHAR_W-1:0] CH_NONE    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } stack_ctrl_t;

  // Digit value 0..35 to its ASCII character.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] dw;
    dw = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (dw < 8'd10) begin
      return CH_ZERO + dw;
    end
    return (upper ? CH_UPPER_A : CH_LOWER_A) + dw - 8'd10;
  endfunction

endpackage

### rtl/itpt_div_unit.sv
// Iterative divider by a small radix: DIV_BITS quotient bits per cycle.
// Depends on itpt_pkg.
module itpt_div_unit import itpt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [RADIX_W-1:0]     radix_i,
  input  logic [VALUE_WIDTH-1:0] dividend_i,
  output logic                   done_o,
  output logic [VALUE_WIDTH-1:0] quotient_o,
  output logic [DIGIT_W-1:0]     remainder_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DIV_W-1:0]  work_q, work_d;
  logic [DIGIT_W-1:0] rem_q, rem_d;

  always_comb begin
    logic [DIGIT_W:0] r;
    logic [DIV_W-1:0] w;
    r = {1'b0, rem_q};
    w = work_q;
    // Restoring division, MSB first; quotient bits shift in at the bottom.
    for (int i = 0; i < DIV_BITS; i++) begin
      r = {r[DIGIT_W-1:0], w[DIV_W-1]};
      w = {w[DIV_W-2:0], 1'b0};
      if (r >= {1'b0, radix_i}) begin
        r = r - {1'b0, radix_i};
        w[0] = 1'b1;
      end
    end

    busy_d = busy_q;
    step_d = step_q;
    work_d = work_q;
    rem_d  = rem_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(DIV_STEPS);
      work_d = DIV_W'(dividend_i);
      rem_d  = '0;
    end else if (busy_q) begin
      work_d = w;
      rem_d  = r[DIGIT_W-1:0];
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = work_q[VALUE_WIDTH-1:0];
  assign remainder_o = rem_q;

endmodule

### rtl/itpt_digit_stack.sv
// Last-in first-out shift line holding digits, least significant pushed first.
// Depends on itpt_pkg.
module itpt_digit_stack import itpt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stack_ctrl_t        ctrl_i,
  input  logic [DIGIT_W-1:0] digit_i,
  output logic [DIGIT_W-1:0] top_o,
  output logic [NDIG_W-1:0]  count_o
);

  logic [DIGIT_W-1:0] stack_q [STACK_DEPTH];
  logic [NDIG_W-1:0]  count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl_i.clear) begin
      count_q <= '0;
    end else if (ctrl_i.push) begin
      count_q <= count_q + NDIG_W'(1);
    end else if (ctrl_i.pop) begin
      count_q <= count_q - NDIG_W'(1);
    end
  end

  // Push shifts entries up, pop shifts them down; the top is always entry 0.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      stack_q[0] <= digit_i;
      for (int i = 1; i < STACK_DEPTH; i++) begin
        stack_q[i] <= stack_q[i-1];
      end
    end else if (ctrl_i.pop) begin
      for (int i = 0; i < STACK_DEPTH - 1; i++) begin
        stack_q[i] <= stack_q[i+1];
      end
    end
  end

  assign top_o   = stack_q[0];
  assign count_o = count_q;

endmodule

### rtl/integer_to_padded_text_core.sv
// Top level of the printf-style integer renderer: sequencer, length logic and
// character emitter. Depends on itpt_pkg, itpt_div_unit and itpt_digit_stack.
//
// An item is taken when start is high and busy is low; busy then stays high
// until the last character has been produced. Characters leave one per
// strobe_o pulse, in order, and must be captured on the cycle they appear
// since the receiver cannot hold them. Digits come from one shared divider
// that retires 8 quotient bits a cycle, one full division per digit; a zero
// value skips the divider. A bad radix yields its single error result, with
// bad_radix_o and last_o set.
module integer_to_padded_text_core import itpt_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [VALUE_PORT_W-1:0] value_i,
  input  logic [RADIX_W-1:0]      radix_i,
  input  logic [FIELD_W-1:0]      field_width_i,
  input  logic [FIELD_W-1:0]      min_digits_i,
  input  logic [FLAGS_W-1:0]      format_flags_i,
  input  logic [FIELD_W-1:0]      room_i,
  output logic                    strobe_o,
  output logic [CHAR_W-1:0]       char_code_o,
  output logic [POS_W-1:0]        position_o,
  output logic                    stored_o,
  output logic                    last_o,
  output logic                    bad_radix_o,
  output logic                    clipped_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PREP = 5'b00010,
    S_DIV  = 5'b00100,
    S_LEN  = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  typedef enum logic [6:0] {
    PH_LEAD  = 7'b0000001,
    PH_SIGN  = 7'b0000010,
    PH_PFX   = 7'b0000100,
    PH_MID   = 7'b0001000,
    PH_ZERO  = 7'b0010000,
    PH_DIG   = 7'b0100000,
    PH_TRAIL = 7'b1000000
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic [FIELD_W-1:0] cnt_q, cnt_d;
  logic [POS_W-1:0]   k_q, k_d;
  logic [POS_W-1:0]   last_idx_q, last_idx_d;
  logic               clip_q, clip_d;
  logic [FIELD_W-1:0] pad_q, pad_d;
  logic [FIELD_W-1:0] prec_q, prec_d;

  // Item fields
  logic [VALUE_WIDTH-1:0] val_q;
  logic [RADIX_W-1:0]     radix_q;
  logic [FIELD_W-1:0]     fw_q, md_q, room_q;
  logic                   left_q, zero_q, signed_q, plus_q, space_q, alt_q, upper_q;
  logic [CHAR_W-1:0]      sign_ch_q, sign_ch_d;
  logic                   has_sign_q, has_sign_d;
  logic [1:0]             pfx_q, pfx_d;

  // Result register
  logic              out_vld_d, out_vld_q;
  logic [CHAR_W-1:0] out_ch_d, out_ch_q;
  logic [POS_W-1:0]  out_pos_d, out_pos_q;
  logic              out_st_d, out_st_q;
  logic              out_last_d, out_last_q;
  logic              out_bad_d, out_bad_q;
  logic              out_clip_d, out_clip_q;

  // Divider and digit stack
  logic                   div_start, div_done;
  logic [VALUE_WIDTH-1:0] div_dividend, div_quot;
  logic [DIGIT_W-1:0]     div_rem;
  stack_ctrl_t            stk_ctrl;
  logic [DIGIT_W-1:0]     stk_digit, stk_top;
  logic [NDIG_W-1:0]      stk_count;

  logic                   accept;
  logic                   neg;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   bad_radix;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  assign neg       = signed_q && val_q[VALUE_WIDTH-1];
  assign mag       = neg ? (~val_q + VALUE_WIDTH'(1)) : val_q;
  assign bad_radix = ({1'b0, radix_q} < 7'(RADIX_MIN)) || ({1'b0, radix_q} > 7'(RADIX_MAX));

  itpt_div_unit u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .radix_i     (radix_q),
    .dividend_i  (div_dividend),
    .done_o      (div_done),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  itpt_digit_stack u_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (stk_ctrl),
    .digit_i (stk_digit),
    .top_o   (stk_top),
    .count_o (stk_count)
  );

  function automatic phase_e next_phase(input phase_e ph);
    case (ph)
      PH_LEAD: return PH_SIGN;
      PH_SIGN: return PH_PFX;
      PH_PFX:  return PH_MID;
      PH_MID:  return PH_ZERO;
      PH_ZERO: return PH_DIG;
      default: return PH_TRAIL;
    endcase
  endfunction

  // Number of characters in each section of the rendering.
  function automatic logic [FIELD_W-1:0] phase_len(input phase_e ph,
                                                   input logic [FIELD_W-1:0] pad,
                                                   input logic [FIELD_W-1:0] prec,
                                                   input logic [FIELD_W-1:0] nd,
                                                   input logic sgn,
                                                   input logic [1:0] pfx,
                                                   input logic left,
                                                   input logic zero);
    case (ph)
      PH_LEAD:  return (left || zero) ? '0 : pad;
      PH_SIGN:  return FIELD_W'(sgn);
      PH_PFX:   return FIELD_W'(pfx);
      PH_MID:   return zero ? pad : '0;
      PH_ZERO:  return prec - nd;
      PH_DIG:   return nd;
      PH_TRAIL: return left ? pad : '0;
      default:  return '0;
    endcase
  endfunction

  always_comb begin
    logic [FIELD_W-1:0] nd;
    logic [FIELD_W:0]   rest, total;
    logic [CHAR_W-1:0]  ch;
    logic               is_last;

    state_d    = state_q;
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    k_d        = k_q;
    last_idx_d = last_idx_q;
    clip_d     = clip_q;
    pad_d      = pad_q;
    prec_d     = prec_q;
    sign_ch_d  = sign_ch_q;
    has_sign_d = has_sign_q;
    pfx_d      = pfx_q;

    out_vld_d  = 1'b0;
    out_ch_d   = CH_NONE;
    out_pos_d  = k_q;
    out_st_d   = 1'b0;
    out_last_d = 1'b0;
    out_bad_d  = 1'b0;
    out_clip_d = 1'b0;

    div_start    = 1'b0;
    div_dividend = div_quot;
    stk_ctrl     = '0;
    stk_digit    = div_rem;

    nd      = FIELD_W'(stk_count);
    rest    = '0;
    total   = '0;
    ch      = CH_NONE;
    is_last = (k_q == last_idx_q);

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          stk_ctrl.clear = 1'b1;
          k_d            = '0;
          state_d        = S_PREP;
        end
      end

      S_PREP: begin
        if (bad_radix) begin
          out_vld_d  = 1'b1;
          out_pos_d  = '0;
          out_last_d = 1'b1;
          out_bad_d  = 1'b1;
          state_d    = S_IDLE;
        end else begin
          if (neg) begin
            sign_ch_d = CH_MINUS;
          end else if (signed_q && plus_q) begin
            sign_ch_d = CH_PLUS;
          end else if (signed_q && space_q) begin
            sign_ch_d = CH_SPACE;
          end else begin
            sign_ch_d = CH_NONE;
          end
          has_sign_d = neg || (signed_q && (plus_q || space_q));
          if (alt_q && ({1'b0, radix_q} == 7'(RADIX_HEX))) begin
            pfx_d = 2'd2;
          end else if (alt_q && ({1'b0, radix_q} == 7'(RADIX_OCT))) begin
            pfx_d = 2'd1;
          end else begin
            pfx_d = 2'd0;
          end
          div_dividend = mag;
          if (mag == '0) begin
            // Zero renders as a single '0' digit.
            stk_ctrl.push = 1'b1;
            stk_digit     = '0;
            state_d       = S_LEN;
          end else begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end
        end
      end

      S_DIV: begin
        if (div_done) begin
          stk_ctrl.push = 1'b1;
          if (div_quot == '0) begin
            state_d = S_LEN;
          end else begin
            div_start = 1'b1;
          end
        end
      end

      S_LEN: begin
        prec_d = (nd > md_q) ? nd : md_q;
        rest   = {7'b0, has_sign_q} + {6'b0, pfx_q} + {1'b0, prec_d};
        total  = ({1'b0, fw_q} > rest) ? {1'b0, fw_q} : rest;
        pad_d  = FIELD_W'(total - rest);
        clip_d = (total > (FIELD_W+1)'(MAX_CHARS));
        last_idx_d = clip_d ? POS_W'(MAX_CHARS - 1) : POS_W'(total - (FIELD_W+1)'(1));
        phase_d = PH_LEAD;
        cnt_d   = phase_len(PH_LEAD, pad_d, prec_d, nd, has_sign_q, pfx_q, left_q, zero_q);
        state_d = S_EMIT;
      end

      S_EMIT: begin
        case (phase_q)
          PH_LEAD:  ch = CH_SPACE;
          PH_SIGN:  ch = sign_ch_q;
          PH_PFX:   ch = ((cnt_q == FIELD_W'(1)) && (pfx_q == 2'd2)) ?
                         (upper_q ? CH_UPPER_X : CH_LOWER_X) : CH_ZERO;
          PH_MID:   ch = CH_ZERO;
          PH_ZERO:  ch = CH_ZERO;
          PH_DIG:   ch = digit_char(stk_top, upper_q);
          PH_TRAIL: ch = CH_SPACE;
          default:  ch = CH_NONE;
        endcase
        if (cnt_q == '0) begin
          // Empty or finished section: move on without a character.
          phase_d = next_phase(phase_q);
          cnt_d   = phase_len(phase_d, pad_q, prec_q, nd, has_sign_q, pfx_q,
                              left_q, zero_q);
        end else begin
          out_vld_d    = 1'b1;
          out_ch_d     = ch;
          out_st_d     = ({1'b0, k_q} < room_q);
          out_last_d   = is_last;
          out_clip_d   = is_last && clip_q;
          cnt_d        = cnt_q - FIELD_W'(1);
          k_d          = k_q + POS_W'(1);
          stk_ctrl.pop = (phase_q == PH_DIG);
          if (is_last) begin
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      phase_q   <= PH_LEAD;
      cnt_q     <= '0;
      k_q       <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      k_q       <= k_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      val_q    <= value_i[VALUE_WIDTH-1:0];
      radix_q  <= radix_i;
      fw_q     <= field_width_i;
      md_q     <= min_digits_i;
      room_q   <= room_i;
      left_q   <= format_flags_i[FLAG_LEFT];
      // Zero padding does not apply when left-aligned.
      zero_q   <= format_flags_i[FLAG_ZERO] && !format_flags_i[FLAG_LEFT];
      signed_q <= format_flags_i[FLAG_SIGNED];
      plus_q   <= format_flags_i[FLAG_PLUS];
      space_q  <= format_flags_i[FLAG_SPACE];
      alt_q    <= format_flags_i[FLAG_ALT];
      upper_q  <= format_flags_i[FLAG_UPPER];
    end
    last_idx_q <= last_idx_d;
    clip_q     <= clip_d;
    pad_q      <= pad_d;
    prec_q     <= prec_d;
    sign_ch_q  <= sign_ch_d;
    has_sign_q <= has_sign_d;
    pfx_q      <= pfx_d;
    if (out_vld_d) begin
      out_ch_q   <= out_ch_d;
      out_pos_q  <= out_pos_d;
      out_st_q   <= out_st_d;
      out_last_q <= out_last_d;
      out_bad_q  <= out_bad_d;
      out_clip_q <= out_clip_d;
    end
  end

  assign strobe_o    = out_vld_q;
  assign char_code_o = out_ch_q;
  assign position_o  = out_pos_q;
  assign stored_o    = out_st_q;
  assign last_o      = out_last_q;
  assign bad_radix_o = out_bad_q;
  assign clipped_o   = out_clip_q;

endmodule

### dv/tb.sv
// Self-checking testbench for integer_to_padded_text_core: renders each sent item
// in a local printf-style model and compares every emitted character field by field.
// Depends on itpt_pkg and the core RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import itpt_pkg::*;

  localparam logic [FLAGS_W-1:0] F_LEFT   = FLAGS_W'(1 << FLAG_LEFT);
  localparam logic [FLAGS_W-1:0] F_ZERO   = FLAGS_W'(1 << FLAG_ZERO);
  localparam logic [FLAGS_W-1:0] F_SIGNED = FLAGS_W'(1 << FLAG_SIGNED);
  localparam logic [FLAGS_W-1:0] F_PLUS   = FLAGS_W'(1 << FLAG_PLUS);
  localparam logic [FLAGS_W-1:0] F_SPACE  = FLAGS_W'(1 << FLAG_SPACE);
  localparam logic [FLAGS_W-1:0] F_ALT    = FLAGS_W'(1 << FLAG_ALT);
  localparam logic [FLAGS_W-1:0] F_UPPER  = FLAGS_W'(1 << FLAG_UPPER);

  localparam logic [VALUE_PORT_W-1:0] MOST_NEG = {1'b1, {(VALUE_PORT_W-1){1'b0}}};
  localparam logic [VALUE_PORT_W-1:0] MOST_POS = {1'b0, {(VALUE_PORT_W-1){1'b1}}};
  localparam logic [VALUE_PORT_W-1:0] ALL_ONES = '1;
  localparam int unsigned FAIL_SHOWN = 10;
  localparam int unsigned RANDOM_ITEMS = 300;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic [POS_W-1:0]  position;
    logic              stored;
    logic              last;
    logic              bad_radix;
    logic              clipped;
  } char_result_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [VALUE_PORT_W-1:0] value_i = '0;
  logic [RADIX_W-1:0]      radix_i = '0;
  logic [FIELD_W-1:0]      field_width_i = '0;
  logic [FIELD_W-1:0]      min_digits_i = '0;
  logic [FLAGS_W-1:0]      format_flags_i = '0;
  logic [FIELD_W-1:0]      room_i = '0;
  logic                    strobe_o;
  logic [CHAR_W-1:0]       char_code_o;
  logic [POS_W-1:0]        position_o;
  logic                    stored_o;
  logic                    last_o;
  logic                    bad_radix_o;
  logic                    clipped_o;

  char_result_t      expected_chars[$];
  logic [CHAR_W-1:0] text_buf[$];
  string             digits_upper = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
  string             digits_lower = "0123456789abcdefghijklmnopqrstuvwxyz";
  int unsigned       fail_count = 0;
  bit                gaps_on = 1'b1;

  integer_to_padded_text_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .value_i        (value_i),
    .radix_i        (radix_i),
    .field_width_i  (field_width_i),
    .min_digits_i   (min_digits_i),
    .format_flags_i (format_flags_i),
    .room_i         (room_i),
    .strobe_o       (strobe_o),
    .char_code_o    (char_code_o),
    .position_o     (position_o),
    .stored_o       (stored_o),
    .last_o         (last_o),
    .bad_radix_o    (bad_radix_o),
    .clipped_o      (clipped_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic string show_char(input char_result_t c);
    return $sformatf("char=%02h pos=%0d stored=%0b last=%0b bad_radix=%0b clipped=%0b",
                     c.char_code, c.position, c.stored, c.last, c.bad_radix, c.clipped);
  endfunction

  task automatic log_fail(input string msg);
    fail_count++;
    if (fail_count <= FAIL_SHOWN) begin
      $display("%0t ns: %s", $realtime, msg);
    end
  endtask

  function automatic void append_run(input logic [CHAR_W-1:0] c, input int count);
    for (int i = 0; i < count; i++) begin
      text_buf.push_back(c);
    end
  endfunction

  // Build the full rendering in text_buf, then queue the characters that leave the block.
  function automatic void render_item(input logic [VALUE_PORT_W-1:0] value,
                                      input logic [RADIX_W-1:0] radix,
                                      input logic [FIELD_W-1:0] fwidth,
                                      input logic [FIELD_W-1:0] mdig,
                                      input logic [FLAGS_W-1:0] flags_in,
                                      input logic [FIELD_W-1:0] room);
    logic [VALUE_WIDTH-1:0] mag;
    logic [FLAGS_W-1:0]     fl;
    logic [CHAR_W-1:0]      sign_ch;
    logic [CHAR_W-1:0]      digs[$];
    int                     pad, prec, pfx, total, n, d;
    char_result_t           r;
    text_buf.delete();
    if (radix < RADIX_MIN || radix > RADIX_MAX) begin
      r = '{CH_NONE, '0, 1'b0, 1'b1, 1'b1, 1'b0};
      expected_chars.push_back(r);
      return;
    end
    mag = value[VALUE_WIDTH-1:0];
    fl = flags_in;
    pad = fwidth;
    prec = mdig;
    pfx = 0;
    sign_ch = CH_NONE;
    if (fl[FLAG_LEFT]) fl[FLAG_ZERO] = 1'b0;
    if (fl[FLAG_SIGNED]) begin
      if (mag[VALUE_WIDTH-1]) begin
        sign_ch = CH_MINUS;
        mag = '0 - mag;
      end else if (fl[FLAG_PLUS]) begin
        sign_ch = CH_PLUS;
      end else if (fl[FLAG_SPACE]) begin
        sign_ch = CH_SPACE;
      end
      if (sign_ch != CH_NONE) pad--;
    end
    if (fl[FLAG_ALT]) begin
      if (radix == RADIX_HEX) pfx = 2;
      else if (radix == RADIX_OCT) pfx = 1;
      pad -= pfx;
    end
    // Digits come out least significant first.
    do begin
      d = int'(mag % radix);
      digs.push_back(fl[FLAG_UPPER] ? digits_upper[d] : digits_lower[d]);
      mag = mag / radix;
    end while (mag != 0);
    if (digs.size() > prec) prec = digs.size();
    pad -= prec;
    if (!fl[FLAG_ZERO] && !fl[FLAG_LEFT]) begin
      append_run(CH_SPACE, pad);
      pad = 0;
    end
    if (sign_ch != CH_NONE) text_buf.push_back(sign_ch);
    if (pfx >= 1) text_buf.push_back(CH_ZERO);
    if (pfx == 2) text_buf.push_back(fl[FLAG_UPPER] ? CH_UPPER_X : CH_LOWER_X);
    if (!fl[FLAG_LEFT]) begin
      append_run(fl[FLAG_ZERO] ? CH_ZERO : CH_SPACE, pad);
      pad = 0;
    end
    append_run(CH_ZERO, prec - digs.size());
    for (int i = digs.size() - 1; i >= 0; i--) begin
      text_buf.push_back(digs[i]);
    end
    append_run(CH_SPACE, pad);
    total = text_buf.size();
    n = (total > MAX_CHARS) ? MAX_CHARS : total;
    for (int k = 0; k < n; k++) begin
      r.char_code = text_buf[k];
      r.position  = POS_W'(k);
      r.stored    = (k < room);
      r.last      = (k == n - 1);
      r.bad_radix = 1'b0;
      r.clipped   = (k == n - 1) && (total > MAX_CHARS);
      expected_chars.push_back(r);
    end
  endfunction

  // Present one item and hold it until the block takes it; start stays high on return.
  task automatic send_item(input logic [VALUE_PORT_W-1:0] v, input logic [RADIX_W-1:0] r,
                           input logic [FIELD_W-1:0] w, input logic [FIELD_W-1:0] md,
                           input logic [FLAGS_W-1:0] fl, input logic [FIELD_W-1:0] rm);
    int gap;
    gap = 0;
    if (gaps_on) begin
      while ($urandom_range(99) < 24) gap++;
    end
    if (gap != 0) begin
      start <= 1'b0;
      @(posedge clk_i);
      // Half the time let the gap fall after the block has gone idle.
      if ($urandom_range(1) == 1) begin
        while (busy) @(posedge clk_i);
      end
      repeat (gap - 1) @(posedge clk_i);
    end
    start          <= 1'b1;
    value_i        <= v;
    radix_i        <= r;
    field_width_i  <= w;
    min_digits_i   <= md;
    format_flags_i <= fl;
    room_i         <= rm;
    do @(posedge clk_i); while (busy);
    render_item(v, r, w, md, fl, rm);
  endtask

  // Drop start and hold off until every queued character has come out.
  task automatic wait_drained();
    start <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : check_chars
    char_result_t got, want;
    if (rst_ni && strobe_o) begin
      got = '{char_code_o, position_o, stored_o, last_o, bad_radix_o, clipped_o};
      if (expected_chars.size() == 0) begin
        log_fail($sformatf("character with nothing pending: %s", show_char(got)));
      end else begin
        want = expected_chars.pop_front();
        if (got !== want) begin
          log_fail($sformatf("expected %s, got %s", show_char(want), show_char(got)));
        end
      end
    end
  end

  task automatic test_bad_radix();
    send_item(64'd123, 6'd0, 7'd5, 7'd3, F_SIGNED, 7'd64);
    send_item(ALL_ONES, 6'd1, 7'd0, 7'd0, 7'h7F, 7'd0);
    send_item(64'd7, 6'd37, 7'd10, 7'd0, F_ALT, 7'd64);
    send_item(MOST_NEG, 6'd63, 7'd127, 7'd127, F_LEFT, 7'd127);
  endtask

  task automatic test_radices();
    send_item(64'd0, 6'd10, 7'd0, 7'd0, '0, 7'd64);
    send_item(64'hDEAD_BEEF_0123_4567, 6'd16, 7'd0, 7'd0, F_UPPER, 7'd64);
    send_item(ALL_ONES, 6'd2, 7'd0, 7'd0, '0, 7'd64);
    send_item(ALL_ONES, 6'd36, 7'd0, 7'd0, '0, 7'd64);
    send_item(64'd12345, 6'd8, 7'd0, 7'd0, '0, 7'd64);
  endtask

  task automatic test_signs();
    send_item(ALL_ONES, 6'd10, 7'd0, 7'd0, F_SIGNED, 7'd64);
    send_item(MOST_NEG, 6'd10, 7'd0, 7'd0, F_SIGNED, 7'd64);
    send_item(MOST_POS, 6'd10, 7'd0, 7'd0, F_SIGNED | F_PLUS, 7'd64);
    send_item(64'd42, 6'd10, 7'd0, 7'd0, F_SIGNED | F_SPACE, 7'd64);
    send_item(64'd42, 6'd10, 7'd0, 7'd0, F_SIGNED | F_PLUS | F_SPACE, 7'd64);
    send_item(64'd42, 6'd10, 7'd0, 7'd0, F_PLUS | F_SPACE, 7'd64);
  endtask

  task automatic test_prefix();
    send_item(64'd8, 6'd8, 7'd0, 7'd0, F_ALT, 7'd64);
    send_item(64'd255, 6'd16, 7'd0, 7'd0, F_ALT, 7'd64);
    send_item(64'd255, 6'd16, 7'd0, 7'd0, F_ALT | F_UPPER, 7'd64);
    send_item(64'd255, 6'd10, 7'd0, 7'd0, F_ALT, 7'd64);
  endtask

  task automatic test_padding();
    send_item(64'd42, 6'd10, 7'd10, 7'd0, '0, 7'd64);
    send_item(-64'sd42, 6'd16, 7'd12, 7'd0, F_SIGNED | F_ZERO | F_ALT, 7'd64);
    send_item(64'd42, 6'd10, 7'd10, 7'd0, F_LEFT | F_ZERO | F_SIGNED | F_PLUS, 7'd64);
    send_item(64'd42, 6'd10, 7'd12, 7'd8, '0, 7'd64);
    send_item(64'd9, 6'd10, 7'd127, 7'd0, F_LEFT, 7'd64);
    send_item(64'd9, 6'd10, 7'd0, 7'd127, '0, 7'd64);
  endtask

  task automatic test_room();
    send_item(64'd31337, 6'd10, 7'd0, 7'd0, '0, 7'd0);
    send_item(64'd31337, 6'd10, 7'd10, 7'd0, '0, 7'd3);
    send_item(64'd31337, 6'd10, 7'd70, 7'd0, F_ZERO, 7'd127);
  endtask

  task automatic test_random();
    logic [VALUE_PORT_W-1:0] v;
    logic [RADIX_W-1:0]      r;
    logic [FIELD_W-1:0]      w, md, rm;
    int                      pick;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      gaps_on = !(i >= 100 && i < 180);
      if (i == 200) wait_drained();
      case ($urandom_range(5))
        0: v = {$urandom, $urandom};
        1: v = VALUE_PORT_W'($urandom_range(999));
        2: v = VALUE_PORT_W'($urandom);
        3: begin
          pick = $urandom_range(3);
          v = (pick == 0) ? '0 : (pick == 1) ? ALL_ONES :
              (pick == 2) ? MOST_NEG : MOST_POS;
        end
        4: v = '0 - VALUE_PORT_W'($urandom_range(1000, 1));
        default: v = {$urandom, $urandom} >> $urandom_range(63);
      endcase
      pick = $urandom_range(99);
      if (pick < 6) begin
        r = ($urandom_range(1) == 1) ? RADIX_W'($urandom_range(1)) :
                                       RADIX_W'($urandom_range(63, 37));
      end else if (pick < 40) begin
        case ($urandom_range(3))
          0: r = RADIX_W'(2);
          1: r = RADIX_W'(RADIX_OCT);
          2: r = RADIX_W'(10);
          default: r = RADIX_W'(RADIX_HEX);
        endcase
      end else begin
        r = RADIX_W'($urandom_range(RADIX_MAX, RADIX_MIN));
      end
      w  = ($urandom_range(9) == 0) ? FIELD_W'($urandom_range(127)) :
                                      FIELD_W'($urandom_range(24));
      md = ($urandom_range(9) == 0) ? FIELD_W'($urandom_range(127)) :
                                      FIELD_W'($urandom_range(20));
      rm = ($urandom_range(7) == 0) ? FIELD_W'($urandom_range(127)) :
                                      FIELD_W'($urandom_range(64));
      send_item(v, r, w, md, FLAGS_W'($urandom_range(127)), rm);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_bad_radix();
    test_radices();
    test_signs();
    test_prefix();
    test_padding();
    test_room();
    wait_drained();
    test_random();
    wait_drained();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/itpt_pkg.sv
rtl/itpt_div_unit.sv
rtl/itpt_digit_stack.sv
rtl/integer_to_padded_text_core.sv
dv/tb.sv
